// ===== rtl/core/tlcd_pkg.sv =====
package tlcd_pkg;

    localparam int TAG_W     = 32;
    localparam int WAY_IDX_W = 4;

    localparam int L1_SETS_DEF = 64;
    localparam int L1_WAYS_DEF = 4;
    localparam int L2_SETS_DEF = 256;
    localparam int L2_WAYS_DEF = 8;

    // Configuration register indexes.
    localparam logic [2:0] CFG_BLOCK_OFFSET = 3'd0;
    localparam logic [2:0] CFG_L1_SET_BITS  = 3'd1;
    localparam logic [2:0] CFG_L1_WAY_BITS  = 3'd2;
    localparam logic [2:0] CFG_L2_SET_BITS  = 3'd3;
    localparam logic [2:0] CFG_L2_WAY_BITS  = 3'd4;
    localparam logic [2:0] CFG_WRITE_ALLOC  = 3'd5;

    localparam logic KIND_WRITE = 1'b1;

    // Operation applied to one set row.
    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_TOUCH   = 2'd1,
        OP_REPLACE = 2'd2,
        OP_INVAL   = 2'd3
    } set_op_t;

    // Lookup and victim status of one set row.
    typedef struct packed {
        logic                 hit;
        logic [WAY_IDX_W-1:0] hit_way;
        logic [WAY_IDX_W-1:0] vic_way;
        logic                 vic_valid;
        logic                 vic_dirty;
        logic [TAG_W-1:0]     vic_tag;
    } set_stat_t;

    function automatic logic [31:0] low_mask(input logic [3:0] n);
        return ~(32'hFFFF_FFFF << n);
    endfunction

endpackage

// ===== rtl/core/two_level_cache_directory_lru.sv =====
// Tag directory of an inclusive two-level set-associative cache with LRU.
// Items enter on the s_ channel: s_tdata is the byte address, s_tuser the
// access kind (0 read, 1 write). One result item per access leaves on the
// m_ channel with the hit flags and the four running counters.
// Geometry and the write-allocate policy are set through the cfg_ port,
// which is always ready; write it only while the directory is idle.
// Each set of each level is one row of a synchronous RAM (tag, valid, dirty
// and age of every way), read, modified and written back by a sequencer.
// One item is handled at a time. An L1 hit or a write that bypasses L1 goes
// from the lookup straight to the done step; a fill into L1 adds a fill step. A
// dirty L1 victim that updates L2 adds a write-back step, and an L2 victim that
// must be removed from L1 adds a back-invalidate step and a re-read of the L1 row.
// One read port per level and the read-after-write order of these steps set them.
// The result item becomes valid in the same cycle that s_tready rises for the next item.
// The result sits in an output register, so the next item is taken while a
// result waits for m_tready; a finished item waits in its last step until the
// register drains, and s_tready stays low meanwhile.
// After reset a clearing pass empties one row of each RAM per cycle, with
// s_tready low, until every row of both RAMs is empty. Reset also
// zeroes the counters and loads the default geometry.
module two_level_cache_directory_lru #(
    parameter int L1_SETS = tlcd_pkg::L1_SETS_DEF,
    parameter int L1_WAYS = tlcd_pkg::L1_WAYS_DEF,
    parameter int L2_SETS = tlcd_pkg::L2_SETS_DEF,
    parameter int L2_WAYS = tlcd_pkg::L2_WAYS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [31:0]   s_tdata,   // address
    input  logic          s_tuser,   // kind
    output logic          m_tvalid,
    input  logic          m_tready,
    // l1_hit, l2_hit, l1_access_count, l1_miss_count, l2_access_count,
    // l2_miss_count, zero padding
    output logic [135:0]  m_tdata,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_addr,
    input  logic [3:0]    cfg_data
);
    import tlcd_pkg::*;

    localparam int L1_AGE_W  = (L1_WAYS > 1) ? $clog2(L1_WAYS) : 1;
    localparam int L1_ROW_W  = L1_WAYS * (34 + L1_AGE_W);
    localparam int L1_SW     = (L1_SETS > 1) ? $clog2(L1_SETS) : 1;
    localparam int L1_SB_MAX = $clog2(L1_SETS + 1) - 1;
    localparam int L1_WB_MAX = $clog2(L1_WAYS + 1) - 1;
    localparam int L2_AGE_W  = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
    localparam int L2_ROW_W  = L2_WAYS * (34 + L2_AGE_W);
    localparam int L2_SW     = (L2_SETS > 1) ? $clog2(L2_SETS) : 1;
    localparam int L2_SB_MAX = $clog2(L2_SETS + 1) - 1;
    localparam int L2_WB_MAX = $clog2(L2_WAYS + 1) - 1;
    localparam int CLR_N     = (L1_SETS > L2_SETS) ? L1_SETS : L2_SETS;
    localparam int CLR_W     = (CLR_N > 1) ? $clog2(CLR_N) : 1;

    typedef enum logic [7:0] {
        ST_CLR  = 8'b00000001,
        ST_IDLE = 8'b00000010,
        ST_LOOK = 8'b00000100,
        ST_BI   = 8'b00001000,
        ST_F1R  = 8'b00010000,
        ST_F1   = 8'b00100000,
        ST_WB   = 8'b01000000,
        ST_DONE = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration.
    logic [3:0] bo_reg;
    logic [2:0] s1b_reg;
    logic [1:0] w1b_reg;
    logic [3:0] s2b_reg;
    logic [1:0] w2b_reg;
    logic       wa_reg;
    logic [3:0] sb1, sb2;
    logic [2:0] wb1, wb2;

    assign sb1 = ({1'b0, s1b_reg} > 4'(L1_SB_MAX)) ? 4'(L1_SB_MAX) : {1'b0, s1b_reg};
    assign sb2 = (s2b_reg > 4'(L2_SB_MAX)) ? 4'(L2_SB_MAX) : s2b_reg;
    assign wb1 = ({1'b0, w1b_reg} > 3'(L1_WB_MAX)) ? 3'(L1_WB_MAX) : {1'b0, w1b_reg};
    assign wb2 = ({1'b0, w2b_reg} > 3'(L2_WB_MAX)) ? 3'(L2_WB_MAX) : {1'b0, w2b_reg};

    // Item under work.
    logic             kind_reg;
    logic [L1_SW-1:0] set1_reg, bi_set_reg;
    logic [31:0]      tag1_reg, bi_tag_reg;
    logic [L2_SW-1:0] set2_reg, wb_set_reg;
    logic [31:0]      tag2_reg, wb_tag_reg;
    logic             h1_reg, h2_reg;
    logic [31:0]      cnt_reg [4];
    logic             m_tvalid_reg;
    logic [135:0]     m_tdata_reg;
    logic [CLR_W-1:0] clr_reg;

    logic [31:0] blk_in;
    logic        accept;
    logic        wr_bypass;

    assign blk_in    = s_tdata >> bo_reg;
    assign accept    = s_tvalid && s_tready;
    assign wr_bypass = (kind_reg == KIND_WRITE) && !wa_reg;

    // Memories.
    logic                re1, we1, re2, we2;
    logic [L1_SW-1:0]    raddr1, waddr1;
    logic [L2_SW-1:0]    raddr2, waddr2;
    logic [L1_ROW_W-1:0] rdata1, row1, upd1, wdata1;
    logic [L2_ROW_W-1:0] rdata2, row2, upd2, wdata2;

    assign row1 = rdata1;
    assign row2 = rdata2;

    // The clearing pass writes empty rows; otherwise the updated row goes back.
    assign wdata1 = (state_reg == ST_CLR) ? '0 : upd1;
    assign wdata2 = (state_reg == ST_CLR) ? '0 : upd2;

    tlcd_ram #(.WIDTH(L1_ROW_W), .DEPTH(L1_SETS)) u_l1_ram (
        .aclk (aclk), .we (we1), .waddr (waddr1), .wdata (wdata1),
        .re (re1), .raddr (raddr1), .rdata (rdata1)
    );

    tlcd_ram #(.WIDTH(L2_ROW_W), .DEPTH(L2_SETS)) u_l2_ram (
        .aclk (aclk), .we (we2), .waddr (waddr2), .wdata (wdata2),
        .re (re2), .raddr (raddr2), .rdata (rdata2)
    );

    // Row update units.
    set_op_t               op1, op2;
    logic [WAY_IDX_W-1:0]  way1, way2;
    logic [31:0]           lk1, lk2, ntag1, ntag2;
    logic                  d1, d2;
    set_stat_t             st1, st2;

    tlcd_set_ops #(.WAYS(L1_WAYS)) u_l1_ops (
        .row_i (row1), .way_bits_i (wb1), .lk_tag_i (lk1), .op_i (op1),
        .op_way_i (way1), .dirty_i (d1), .new_tag_i (ntag1),
        .stat_o (st1), .row_o (upd1)
    );

    tlcd_set_ops #(.WAYS(L2_WAYS)) u_l2_ops (
        .row_i (row2), .way_bits_i (wb2), .lk_tag_i (lk2), .op_i (op2),
        .op_way_i (way2), .dirty_i (d2), .new_tag_i (ntag2),
        .stat_o (st2), .row_o (upd2)
    );

    // Victim blocks rebuilt from their tags and moved to the other level.
    logic [31:0] vb2, vb1;

    assign vb2 = (st2.vic_tag << sb2) | 32'(set2_reg);
    assign vb1 = (st1.vic_tag << sb1) | 32'(set1_reg);

    always_comb begin
        state_next = state_reg;
        re1 = 1'b0; raddr1 = set1_reg; we1 = 1'b0; waddr1 = set1_reg;
        re2 = 1'b0; raddr2 = set2_reg; we2 = 1'b0; waddr2 = set2_reg;
        op1 = OP_NONE; way1 = '0; lk1 = tag1_reg; d1 = 1'b0; ntag1 = tag1_reg;
        op2 = OP_NONE; way2 = '0; lk2 = tag2_reg; d2 = 1'b0; ntag2 = tag2_reg;
        unique case (state_reg)
            ST_CLR: begin
                we1 = (clr_reg <= CLR_W'(L1_SETS - 1));
                waddr1 = L1_SW'(clr_reg);
                we2 = (clr_reg <= CLR_W'(L2_SETS - 1));
                waddr2 = L2_SW'(clr_reg);
                if (clr_reg == CLR_W'(CLR_N - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                raddr1 = L1_SW'(blk_in & low_mask(sb1));
                raddr2 = L2_SW'(blk_in & low_mask(sb2));
                if (accept) begin
                    re1 = 1'b1;
                    re2 = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (st1.hit) begin
                    op1 = OP_TOUCH; way1 = st1.hit_way; d1 = kind_reg;
                    we1 = 1'b1;
                    state_next = ST_DONE;
                end else if (st2.hit) begin
                    op2 = OP_TOUCH; way2 = st2.hit_way; d2 = wr_bypass;
                    we2 = 1'b1;
                    if (wr_bypass) begin
                        state_next = ST_DONE;
                    end else begin
                        re1 = 1'b1;
                        state_next = ST_F1;
                    end
                end else if (wr_bypass) begin
                    state_next = ST_DONE;
                end else begin
                    op2 = OP_REPLACE; way2 = st2.vic_way;
                    we2 = 1'b1;
                    re1 = 1'b1;
                    if (st2.vic_valid) begin
                        // Inclusion: the L2 victim must leave L1 too.
                        raddr1 = L1_SW'(vb2 & low_mask(sb1));
                        state_next = ST_BI;
                    end else begin
                        state_next = ST_F1;
                    end
                end
            end
            ST_BI: begin
                lk1 = bi_tag_reg;
                waddr1 = bi_set_reg;
                if (st1.hit) begin
                    op1 = OP_INVAL; way1 = st1.hit_way;
                    we1 = 1'b1;
                end
                state_next = ST_F1R;
            end
            ST_F1R: begin
                re1 = 1'b1;
                state_next = ST_F1;
            end
            ST_F1: begin
                op1 = OP_REPLACE; way1 = st1.vic_way; d1 = kind_reg;
                we1 = 1'b1;
                if (st1.vic_valid && st1.vic_dirty) begin
                    re2 = 1'b1;
                    raddr2 = L2_SW'(vb1 & low_mask(sb2));
                    state_next = ST_WB;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_WB: begin
                lk2 = wb_tag_reg;
                waddr2 = wb_set_reg;
                if (st2.hit) begin
                    op2 = OP_TOUCH; way2 = st2.hit_way; d2 = 1'b1;
                    we2 = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR;
            clr_reg      <= '0;
            bo_reg       <= 4'd4;
            s1b_reg      <= 3'd6;
            w1b_reg      <= 2'd2;
            s2b_reg      <= 4'd8;
            w2b_reg      <= 2'd3;
            wa_reg       <= 1'b1;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_valid) begin
                unique case (cfg_addr)
                    CFG_BLOCK_OFFSET: bo_reg  <= (cfg_data > 4'd8) ? 4'd8 : cfg_data;
                    CFG_L1_SET_BITS:  s1b_reg <= (cfg_data[2:0] > 3'd6) ? 3'd6 : cfg_data[2:0];
                    CFG_L1_WAY_BITS:  w1b_reg <= (cfg_data[1:0] > 2'd2) ? 2'd2 : cfg_data[1:0];
                    CFG_L2_SET_BITS:  s2b_reg <= (cfg_data > 4'd8) ? 4'd8 : cfg_data;
                    CFG_L2_WAY_BITS:  w2b_reg <= cfg_data[1:0];
                    CFG_WRITE_ALLOC:  wa_reg  <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (state_reg == ST_LOOK) begin
                cnt_reg[0] <= cnt_reg[0] + 32'd1;
                if (!st1.hit) begin
                    cnt_reg[1] <= cnt_reg[1] + 32'd1;
                    cnt_reg[2] <= cnt_reg[2] + 32'd1;
                    if (!st2.hit) begin
                        cnt_reg[3] <= cnt_reg[3] + 32'd1;
                    end
                end
            end
            if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= s_tuser;
            set1_reg <= L1_SW'(blk_in & low_mask(sb1));
            tag1_reg <= blk_in >> sb1;
            set2_reg <= L2_SW'(blk_in & low_mask(sb2));
            tag2_reg <= blk_in >> sb2;
        end
        if (state_reg == ST_LOOK) begin
            h1_reg     <= st1.hit;
            h2_reg     <= !st1.hit && st2.hit;
            bi_set_reg <= L1_SW'(vb2 & low_mask(sb1));
            bi_tag_reg <= vb2 >> sb1;
        end
        if (state_reg == ST_F1) begin
            wb_set_reg <= L2_SW'(vb1 & low_mask(sb2));
            wb_tag_reg <= vb1 >> sb2;
        end
        if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {6'd0, cnt_reg[3], cnt_reg[2], cnt_reg[1], cnt_reg[0],
                            h2_reg, h1_reg};
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

    // Every L1 miss is an L2 access, so those two counters move together.
    a_l1miss_l2acc: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg[1] == cnt_reg[2])
        else $error("L1 miss and L2 access counts differ");

    // A row is never read in the cycle it is written, or stale data would return.
    a_l1_rw: assert property (@(posedge aclk) disable iff (!aresetn)
        !(re1 && we1 && raddr1 == waddr1))
        else $error("L1 row read and written in the same cycle");

    a_l2_rw: assert property (@(posedge aclk) disable iff (!aresetn)
        !(re2 && we2 && raddr2 == waddr2))
        else $error("L2 row read and written in the same cycle");

    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    // An accepted item always produces a result before the next is taken.
    a_item_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && state_next == ST_IDLE) |=> m_tvalid_reg)
        else $error("finished item did not reach the output register");

endmodule

// ===== rtl/core/tlcd_ram.sv =====
module tlcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/tlcd_set_ops.sv =====
module tlcd_set_ops #(
    parameter int WAYS = 4,
    localparam int AGE_W = (WAYS > 1) ? $clog2(WAYS) : 1,
    localparam int EW    = 34 + AGE_W,
    localparam int ROW_W = WAYS * EW
) (
    input  logic [ROW_W-1:0]                row_i,
    input  logic [2:0]                      way_bits_i,
    input  logic [tlcd_pkg::TAG_W-1:0]      lk_tag_i,
    input  tlcd_pkg::set_op_t               op_i,
    input  logic [tlcd_pkg::WAY_IDX_W-1:0]  op_way_i,
    input  logic                            dirty_i,
    input  logic [tlcd_pkg::TAG_W-1:0]      new_tag_i,
    output tlcd_pkg::set_stat_t             stat_o,
    output logic [ROW_W-1:0]                row_o
);
    import tlcd_pkg::*;

    logic [TAG_W-1:0] tag   [WAYS];
    logic             vld   [WAYS];
    logic             drt   [WAYS];
    logic [AGE_W-1:0] age   [WAYS];
    logic             act   [WAYS];
    logic [TAG_W-1:0] n_tag [WAYS];
    logic             n_vld [WAYS];
    logic             n_drt [WAYS];
    logic [AGE_W-1:0] n_age [WAYS];
    logic [4:0]       nw;

    assign nw = 5'd1 << way_bits_i;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            tag[w] = row_i[w*EW +: TAG_W];
            vld[w] = row_i[w*EW + 32];
            drt[w] = row_i[w*EW + 33];
            age[w] = row_i[w*EW + 34 +: AGE_W];
            act[w] = (w < int'(nw));
        end
    end

    // Lookup and victim choice: first free way, else the oldest one.
    always_comb begin
        logic             found;
        logic [AGE_W-1:0] best_age;
        int               best;
        stat_o   = '0;
        found    = 1'b0;
        best     = 0;
        best_age = age[0];
        for (int w = 0; w < WAYS; w++) begin
            if (!stat_o.hit && act[w] && vld[w] && tag[w] == lk_tag_i) begin
                stat_o.hit     = 1'b1;
                stat_o.hit_way = WAY_IDX_W'(w);
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            if (!found && act[w] && !vld[w]) begin
                found = 1'b1;
                best  = w;
            end
        end
        if (!found) begin
            for (int w = 1; w < WAYS; w++) begin
                if (act[w] && age[w] > best_age) begin
                    best     = w;
                    best_age = age[w];
                end
            end
        end
        stat_o.vic_way = WAY_IDX_W'(best);
        for (int w = 0; w < WAYS; w++) begin
            if (w == best) begin
                stat_o.vic_valid = vld[w];
                stat_o.vic_dirty = drt[w];
                stat_o.vic_tag   = tag[w];
            end
        end
    end

    // Row update: touch, invalidate or replace the selected way, adjusting the other ages.
    always_comb begin
        logic [AGE_W-1:0] a_sel;
        logic             v_sel;
        int               cnt;
        a_sel = '0;
        v_sel = 1'b0;
        cnt   = 0;
        for (int w = 0; w < WAYS; w++) begin
            n_tag[w] = tag[w];
            n_vld[w] = vld[w];
            n_drt[w] = drt[w];
            n_age[w] = age[w];
            if (w == int'(op_way_i)) begin
                a_sel = age[w];
                v_sel = vld[w];
            end
        end
        unique case (op_i)
            OP_NONE: begin
            end
            OP_TOUCH: begin
                for (int w = 0; w < WAYS; w++) begin
                    if (w == int'(op_way_i)) begin
                        n_age[w] = '0;
                        if (dirty_i) begin
                            n_drt[w] = 1'b1;
                        end
                    end else if (act[w] && vld[w] && age[w] < a_sel) begin
                        n_age[w] = age[w] + 1'b1;
                    end
                end
            end
            OP_INVAL: begin
                for (int w = 0; w < WAYS; w++) begin
                    if (w == int'(op_way_i)) begin
                        n_vld[w] = 1'b0;
                        n_drt[w] = 1'b0;
                        n_age[w] = '0;
                    end else if (act[w] && vld[w] && age[w] > a_sel) begin
                        n_age[w] = age[w] - 1'b1;
                    end
                end
            end
            OP_REPLACE: begin
                // Retire the old occupant, then enter the new block as most recent.
                for (int w = 0; w < WAYS; w++) begin
                    if (w != int'(op_way_i) && v_sel && act[w] && vld[w]
                        && age[w] > a_sel) begin
                        n_age[w] = age[w] - 1'b1;
                    end
                    if (w != int'(op_way_i) && act[w] && vld[w]) begin
                        cnt = cnt + 1;
                    end
                end
                for (int w = 0; w < WAYS; w++) begin
                    if (w == int'(op_way_i)) begin
                        n_tag[w] = new_tag_i;
                        n_vld[w] = 1'b1;
                        n_drt[w] = dirty_i;
                        n_age[w] = '0;
                    end else if (act[w] && vld[w] && n_age[w] < AGE_W'(cnt)) begin
                        n_age[w] = n_age[w] + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            row_o[w*EW +: EW] = {n_age[w], n_drt[w], n_vld[w], n_tag[w]};
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    import tlcd_pkg::*;

    localparam int NL1S = 64, NL1W = 4, NL2S = 256, NL2W = 8;
    localparam int MAX_CYCLES = 400000;

    // One access as it is offered on the input channel.
    typedef struct {
        logic        kind;
        logic [31:0] address;
    } access_t;

    // One result item as carried on m_tdata.
    typedef struct {
        logic        l1_hit;
        logic        l2_hit;
        logic [31:0] l1_acc;
        logic [31:0] l1_miss;
        logic [31:0] l2_acc;
        logic [31:0] l2_miss;
    } outcome_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_addr = '0;
    logic [3:0]   cfg_data = '0;

    always #1 aclk = ~aclk;

    two_level_cache_directory_lru i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr),
        .cfg_data(cfg_data)
    );

    // Shadow copy of the directory.  Arrays are sized for the largest
    // geometry, rows are indexed set * physical ways + way.
    logic [31:0] l1_tag [NL1S*NL1W];
    logic        l1_vld [NL1S*NL1W];
    logic        l1_drt [NL1S*NL1W];
    int          l1_age [NL1S*NL1W];
    logic [31:0] l2_tag [NL2S*NL2W];
    logic        l2_vld [NL2S*NL2W];
    logic        l2_drt [NL2S*NL2W];
    int          l2_age [NL2S*NL2W];
    logic [31:0] cnt_l1_acc, cnt_l1_miss, cnt_l2_acc, cnt_l2_miss;
    int          offset_bits, l1_sbits, l1_wbits, l2_sbits, l2_wbits;
    logic        alloc_on_write;

    outcome_t pending_outcomes[$];
    bit       failed = 1'b0;
    int       cycle_count = 0;
    bit       hold_off = 1'b0;

    // Level-generic helpers: lvl 1 or 2 picks the array set.
    function automatic int phys_ways(int lvl);
        return (lvl == 1) ? NL1W : NL2W;
    endfunction

    function automatic int set_bits(int lvl);
        return (lvl == 1) ? l1_sbits : l2_sbits;
    endfunction

    function automatic int way_count(int lvl);
        return 1 << ((lvl == 1) ? l1_wbits : l2_wbits);
    endfunction

    function automatic logic [31:0] set_idx(int lvl, logic [31:0] blk);
        return blk & ~(32'hFFFF_FFFF << set_bits(lvl));
    endfunction

    function automatic logic [31:0] tag_val(int lvl, logic [31:0] blk);
        return blk >> set_bits(lvl);
    endfunction

    function automatic bit row_valid(int lvl, int i);
        return (lvl == 1) ? l1_vld[i] : l2_vld[i];
    endfunction

    function automatic int row_age(int lvl, int i);
        return (lvl == 1) ? l1_age[i] : l2_age[i];
    endfunction

    function automatic void set_age(int lvl, int i, int a);
        if (lvl == 1) l1_age[i] = a;
        else l2_age[i] = a;
    endfunction

    function automatic int find_way(int lvl, logic [31:0] blk);
        int base;
        logic [31:0] t;
        base = set_idx(lvl, blk) * phys_ways(lvl);
        t = tag_val(lvl, blk);
        for (int w = 0; w < way_count(lvl); w++) begin
            if (lvl == 1 && l1_vld[base+w] && l1_tag[base+w] == t) return w;
            if (lvl == 2 && l2_vld[base+w] && l2_tag[base+w] == t) return w;
        end
        return -1;
    endfunction

    // Make a way most recent, aging the younger ones of its set.
    function automatic void make_recent(int lvl, int s, int w, bit was_valid);
        int base, old;
        base = s * phys_ways(lvl);
        old = 0;
        if (was_valid) begin
            old = row_age(lvl, base + w);
        end else begin
            for (int v = 0; v < way_count(lvl); v++)
                if (v != w && row_valid(lvl, base + v)) old++;
        end
        for (int v = 0; v < way_count(lvl); v++)
            if (v != w && row_valid(lvl, base + v) && row_age(lvl, base + v) < old)
                set_age(lvl, base + v, row_age(lvl, base + v) + 1);
        set_age(lvl, base + w, 0);
    endfunction

    function automatic void drop_way(int lvl, int s, int w);
        int base, a;
        base = s * phys_ways(lvl);
        a = row_age(lvl, base + w);
        if (lvl == 1) begin
            l1_vld[base+w] = 0;
            l1_drt[base+w] = 0;
        end else begin
            l2_vld[base+w] = 0;
            l2_drt[base+w] = 0;
        end
        for (int v = 0; v < way_count(lvl); v++)
            if (v != w && row_valid(lvl, base + v) && row_age(lvl, base + v) > a)
                set_age(lvl, base + v, row_age(lvl, base + v) - 1);
        set_age(lvl, base + w, 0);
    endfunction

    function automatic int choose_victim(int lvl, int s);
        int base, best;
        base = s * phys_ways(lvl);
        best = 0;
        for (int w = 0; w < way_count(lvl); w++)
            if (!row_valid(lvl, base + w)) return w;
        for (int w = 1; w < way_count(lvl); w++)
            if (row_age(lvl, base + w) > row_age(lvl, base + best)) best = w;
        return best;
    endfunction

    function automatic void install(int lvl, int s, int w, logic [31:0] blk, bit d);
        int i;
        i = s * phys_ways(lvl) + w;
        if (lvl == 1) begin
            l1_tag[i] = tag_val(1, blk);
            l1_vld[i] = 1;
            l1_drt[i] = d;
        end else begin
            l2_tag[i] = tag_val(2, blk);
            l2_vld[i] = 1;
            l2_drt[i] = d;
        end
        make_recent(lvl, s, w, 1'b0);
    endfunction

    // L2 fill; an evicted L2 block is also removed from L1 to stay inclusive.
    function automatic void fill_outer(logic [31:0] blk);
        int s, w, i, w1;
        logic [31:0] vb;
        s = set_idx(2, blk);
        w = choose_victim(2, s);
        i = s * NL2W + w;
        if (l2_vld[i]) begin
            vb = (l2_tag[i] << l2_sbits) | s;
            w1 = find_way(1, vb);
            if (w1 >= 0) drop_way(1, set_idx(1, vb), w1);
            drop_way(2, s, w);
        end
        install(2, s, w, blk, 1'b0);
    endfunction

    // L1 fill; a dirty L1 victim marks its L2 copy dirty and most recent.
    function automatic void fill_inner(logic [31:0] blk, bit d);
        int s, w, i, w2, s2;
        logic [31:0] vb;
        s = set_idx(1, blk);
        w = choose_victim(1, s);
        i = s * NL1W + w;
        if (l1_vld[i]) begin
            if (l1_drt[i]) begin
                vb = (l1_tag[i] << l1_sbits) | s;
                w2 = find_way(2, vb);
                if (w2 >= 0) begin
                    s2 = set_idx(2, vb);
                    l2_drt[s2*NL2W + w2] = 1;
                    make_recent(2, s2, w2, 1'b1);
                end
            end
            drop_way(1, s, w);
        end
        install(1, s, w, blk, d);
    endfunction

    function automatic outcome_t predict_access(access_t a);
        outcome_t r;
        logic [31:0] blk;
        int w1, w2, s;
        blk = a.address >> offset_bits;
        r.l1_hit = 0;
        r.l2_hit = 0;
        cnt_l1_acc++;
        w1 = find_way(1, blk);
        if (w1 >= 0) begin
            s = set_idx(1, blk);
            r.l1_hit = 1;
            if (a.kind) l1_drt[s*NL1W + w1] = 1;
            make_recent(1, s, w1, 1'b1);
        end else begin
            cnt_l1_miss++;
            cnt_l2_acc++;
            w2 = find_way(2, blk);
            if (w2 >= 0) begin
                s = set_idx(2, blk);
                r.l2_hit = 1;
                if (a.kind && !alloc_on_write) l2_drt[s*NL2W + w2] = 1;
                make_recent(2, s, w2, 1'b1);
                if (!(a.kind && !alloc_on_write)) fill_inner(blk, a.kind);
            end else begin
                cnt_l2_miss++;
                if (!a.kind || alloc_on_write) begin
                    fill_outer(blk);
                    fill_inner(blk, a.kind);
                end
            end
        end
        r.l1_acc = cnt_l1_acc;
        r.l1_miss = cnt_l1_miss;
        r.l2_acc = cnt_l2_acc;
        r.l2_miss = cnt_l2_miss;
        return r;
    endfunction

    function automatic int clamp(int v, int top);
        return (v > top) ? top : v;
    endfunction

    // Each register keeps only its own width before saturating.
    function automatic void shadow_config(logic [2:0] idx, logic [3:0] val);
        case (idx)
            CFG_BLOCK_OFFSET: offset_bits = clamp(int'(val), 8);
            CFG_L1_SET_BITS:  l1_sbits = clamp(int'(val[2:0]), 6);
            CFG_L1_WAY_BITS:  l1_wbits = clamp(int'(val[1:0]), 2);
            CFG_L2_SET_BITS:  l2_sbits = clamp(int'(val), 8);
            CFG_L2_WAY_BITS:  l2_wbits = clamp(int'(val[1:0]), 3);
            CFG_WRITE_ALLOC:  alloc_on_write = val[0];
            default: ;
        endcase
    endfunction

    // A gap of idle cycles on the input; the item offer is withdrawn first.
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) n = 0;
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Offers one access, predicts it on acceptance.  The offer stays up
    // until the next access or a gap replaces it.
    task automatic send_access(access_t a);
        outcome_t p;
        s_tvalid <= 1'b1;
        s_tdata <= a.address;
        s_tuser <= a.kind;
        do @(posedge aclk); while (!s_tready);
        p = predict_access(a);
        pending_outcomes = {pending_outcomes, p};
    endtask

    task automatic write_reg(logic [2:0] idx, logic [3:0] val);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        shadow_config(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Waits for the directory to drain before touching the geometry.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    // Sink: random back-pressure, plus one long hold-off requested by the
    // stimulus so that the output register fills and the input stalls.
    always @(posedge aclk) begin
        if (!aresetn || hold_off) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        outcome_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.l1_hit = m_tdata[0];
            got.l2_hit = m_tdata[1];
            got.l1_acc = m_tdata[33:2];
            got.l1_miss = m_tdata[65:34];
            got.l2_acc = m_tdata[97:66];
            got.l2_miss = m_tdata[129:98];
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected result item %h", $time, m_tdata);
                failed = 1'b1;
            end else begin
                want = pending_outcomes.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected h1=%b h2=%b %0d %0d %0d %0d", $time,
                             want.l1_hit, want.l2_hit, want.l1_acc, want.l1_miss,
                             want.l2_acc, want.l2_miss);
                    $display("%0t:          actual   h1=%b h2=%b %0d %0d %0d %0d", $time,
                             got.l1_hit, got.l2_hit, got.l1_acc, got.l1_miss,
                             got.l2_acc, got.l2_miss);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Directed accesses under the reset geometry (16-byte blocks, 64x4 / 256x8).
    // A fresh directory misses twice, a repeat hits in L1.  The rest are
    // checked through the shadow copy only.
    localparam int N_DIRECTED = 14;
    access_t directed_accesses [N_DIRECTED] = '{
        '{1'b0, 32'h0000_0000}, '{1'b0, 32'h0000_000F}, '{1'b1, 32'hFFFF_FFFF},
        '{1'b1, 32'hFFFF_FFF0}, '{1'b0, 32'h0000_0400}, '{1'b1, 32'h0000_0800},
        '{1'b0, 32'h0000_0C00}, '{1'b0, 32'h0000_1000}, '{1'b0, 32'h0000_0000},
        '{1'b1, 32'h0001_0000}, '{1'b1, 32'h0002_0000}, '{1'b0, 32'h0003_0000},
        '{1'b0, 32'h0004_0000}, '{1'b0, 32'h5555_5555}
    };

    // Address pool that keeps blocks colliding within a few sets.
    function automatic access_t random_access();
        access_t a;
        a.kind = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 7) == 0) a.address = $urandom();
        else a.address = ($urandom_range(0, 63) << $urandom_range(4, 12))
                         ^ $urandom_range(0, 255);
        return a;
    endfunction

    initial begin
        access_t a;
        logic [3:0] geo [6];
        outcome_t want;
        foreach (l1_vld[i]) begin
            l1_vld[i] = 0; l1_drt[i] = 0; l1_age[i] = 0; l1_tag[i] = 0;
        end
        foreach (l2_vld[i]) begin
            l2_vld[i] = 0; l2_drt[i] = 0; l2_age[i] = 0; l2_tag[i] = 0;
        end
        cnt_l1_acc = 0; cnt_l1_miss = 0; cnt_l2_acc = 0; cnt_l2_miss = 0;
        offset_bits = 4; l1_sbits = 6; l1_wbits = 2; l2_sbits = 8; l2_wbits = 3;
        alloc_on_write = 1;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (3) @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_access(directed_accesses[i]);
            if (i == 0) begin
                // First access after reset: both levels miss, every count is one.
                want = pending_outcomes[pending_outcomes.size()-1];
                if (want.l1_hit !== 1'b0 || want.l2_hit !== 1'b0 ||
                    want.l1_acc !== 32'd1 || want.l1_miss !== 32'd1 ||
                    want.l2_acc !== 32'd1 || want.l2_miss !== 32'd1) begin
                    $display("%0t: mismatch expected h1=0 h2=0 1 1 1 1", $time);
                    $display("%0t:          actual   h1=%b h2=%b %0d %0d %0d %0d", $time,
                             want.l1_hit, want.l2_hit, want.l1_acc, want.l1_miss,
                             want.l2_acc, want.l2_miss);
                    failed = 1'b1;
                end
            end
            idle_gap();
        end

        // Long receiver hold-off while items keep coming.
        hold_off = 1'b1;
        fork
            begin
                repeat (200) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 6; i++) send_access(random_access());
        join

        // Phases over several geometries, the extremes and saturation included.
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            case (ph)
                0: geo = '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
                1: geo = '{4'd15, 4'd7, 4'd3, 4'd15, 4'd3, 4'd1};
                2: geo = '{4'd2, 4'd1, 4'd1, 4'd2, 4'd2, 4'd0};
                3: geo = '{4'd8, 4'd6, 4'd2, 4'd8, 4'd3, 4'd1};
                default: geo = '{4'($urandom_range(0, 15)), 4'($urandom_range(0, 7)),
                                 4'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                                 4'($urandom_range(0, 3)), 4'($urandom_range(0, 15))};
            endcase
            write_reg(CFG_BLOCK_OFFSET, geo[0]);
            write_reg(CFG_L1_SET_BITS, geo[1]);
            write_reg(CFG_L1_WAY_BITS, geo[2]);
            write_reg(CFG_L2_SET_BITS, geo[3]);
            write_reg(CFG_L2_WAY_BITS, geo[4]);
            write_reg(CFG_WRITE_ALLOC, geo[5]);
            if (ph == 2) write_reg(3'd7, 4'd9);
            for (int i = 0; i < 110; i++) begin
                a = random_access();
                send_access(a);
                if ($urandom_range(0, 3) == 0) begin
                    send_access(a);
                end
                idle_gap();
            end
        end

        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (!failed) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
